### src/dou_pkg.sv
// Shared types and constants for the differential odometry update block.
// Holds the micro-op codes, the control word layout, fixed-point constants
// and the arctangent table. No dependencies.
package dou_pkg;

  // Program counter and loop counter widths.
  localparam int PC_W   = 5;
  localparam int ITER_W = 5;

  // Micro-operation codes, one per datapath step.
  typedef logic [4:0] op_t;
  localparam op_t OP_IDLE   = 5'd0;
  localparam op_t OP_MUL_L  = 5'd1;
  localparam op_t OP_MUL_R  = 5'd2;
  localparam op_t OP_RSCALE = 5'd3;
  localparam op_t OP_SUMS   = 5'd4;
  localparam op_t OP_MUL_TL = 5'd5;
  localparam op_t OP_MUL_TH = 5'd6;
  localparam op_t OP_TURN   = 5'd7;
  localparam op_t OP_DTH    = 5'd8;
  localparam op_t OP_MID    = 5'd9;
  localparam op_t OP_FOLD   = 5'd10;
  localparam op_t OP_ROT    = 5'd11;
  localparam op_t OP_CS     = 5'd12;
  localparam op_t OP_MUL_XL = 5'd13;
  localparam op_t OP_MUL_XH = 5'd14;
  localparam op_t OP_MUL_YL = 5'd15;
  localparam op_t OP_MUL_YH = 5'd16;
  localparam op_t OP_ACC_X  = 5'd17;
  localparam op_t OP_STEP_Y = 5'd18;
  localparam op_t OP_ACC_Y  = 5'd19;
  localparam op_t OP_SAT_Y  = 5'd20;
  localparam op_t OP_PUB    = 5'd21;

  // Jump conditions of a control word.
  typedef logic [1:0] cond_t;
  localparam cond_t COND_NONE     = 2'd0;
  localparam cond_t COND_WAIT_IN  = 2'd1;
  localparam cond_t COND_LOOP     = 2'd2;
  localparam cond_t COND_OUT_BUSY = 2'd3;

  // One control word of the microprogram.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  // Sequencer to datapath control.
  typedef struct packed {
    op_t               op;
    logic [ITER_W-1:0] iter;
  } ctl_t;

  // Status fed back to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } stat_t;

  // Configuration register indexes.
  localparam logic REG_COUNT_SCALE   = 1'b0;
  localparam logic REG_INV_WHEELBASE = 1'b1;

  localparam logic [31:0] COUNT_SCALE_RST   = 32'd16777216;
  localparam logic [31:0] INV_WHEELBASE_RST = 32'd42949673;

  // Angle constants in Q3.28, CORDIC gain in Q2.30.
  localparam logic [29:0]        PI_MAG      = 30'd843314857;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629714;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent of 2^-i in Q2.30.
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

endpackage

### src/dou_seq.sv
// Microprogram sequencer for the odometry update: control store, step
// counter, CORDIC loop counter and conditional jumps.
// Depends on dou_pkg.
module dou_seq
  import dou_pkg::*;
#(
  parameter int LOOP_STEPS = 24
) (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [PC_W-1:0]   PC_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0]   PC_ROT    = PC_W'(11);
  localparam logic [PC_W-1:0]   PC_PUB    = PC_W'(21);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(LOOP_STEPS - 1);

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  logic [ITER_W-1:0] iter;
  logic [ITER_W-1:0] iter_next;
  ucode_t            uw;
  logic              jump;

  // Control store: one word per step of the update.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      PC_W'(0):  w = '{OP_IDLE,   COND_WAIT_IN,  PC_IDLE, 1'b0};
      PC_W'(1):  w = '{OP_MUL_L,  COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(2):  w = '{OP_MUL_R,  COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(3):  w = '{OP_RSCALE, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(4):  w = '{OP_SUMS,   COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(5):  w = '{OP_MUL_TL, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(6):  w = '{OP_MUL_TH, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(7):  w = '{OP_TURN,   COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(8):  w = '{OP_DTH,    COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(9):  w = '{OP_MID,    COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(10): w = '{OP_FOLD,   COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(11): w = '{OP_ROT,    COND_LOOP,     PC_ROT,  1'b0};
      PC_W'(12): w = '{OP_CS,     COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(13): w = '{OP_MUL_XL, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(14): w = '{OP_MUL_XH, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(15): w = '{OP_MUL_YL, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(16): w = '{OP_MUL_YH, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(17): w = '{OP_ACC_X,  COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(18): w = '{OP_STEP_Y, COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(19): w = '{OP_ACC_Y,  COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(20): w = '{OP_SAT_Y,  COND_NONE,     PC_IDLE, 1'b0};
      PC_W'(21): w = '{OP_PUB,    COND_OUT_BUSY, PC_PUB,  1'b1};
      default:   w = '{OP_IDLE,   COND_NONE,     PC_IDLE, 1'b1};
    endcase
    return w;
  endfunction

  // Decode the current word and pick the next step.
  always_comb begin
    uw = ucode_rom(pc);
    unique case (uw.cond)
      COND_WAIT_IN:  jump = !stat.in_valid;
      COND_LOOP:     jump = (iter != ITER_LAST);
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b0;
    endcase
    if (jump) begin
      pc_next = uw.target;
    end else if (uw.last) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + PC_W'(1);
    end
    if (uw.cond == COND_LOOP && jump) begin
      iter_next = iter + ITER_W'(1);
    end else begin
      iter_next = '0;
    end
    ctl.op   = uw.op;
    ctl.iter = iter;
  end

  // Step counter and loop counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_IDLE;
      iter <= '0;
    end else begin
      pc   <= pc_next;
      iter <= iter_next;
    end
  end

endmodule

### src/dou_dp.sv
// Datapath of the odometry update: pose state, one shared 32x32 multiplier,
// the CORDIC shift-add unit and the scratch registers between steps.
// Depends on dou_pkg; driven by the control word from dou_seq.
module dou_dp
  import dou_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic               take,
  input  logic [31:0]        count_left,
  input  logic [31:0]        count_right,
  input  logic [31:0]        count_scale,
  input  logic [31:0]        inv_wheelbase,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [30:0] heading
);

  localparam logic signed [58:0] SUM_MAX = 59'sd140737488355327;
  localparam logic signed [58:0] SUM_MIN = -59'sd140737488355328;

  // Saturate a position sum to the signed 48-bit range.
  function automatic logic [47:0] sat48(input logic [58:0] v);
    logic [47:0] r;
    if ($signed(v) > SUM_MAX) begin
      r = SUM_MAX[47:0];
    end else if ($signed(v) < SUM_MIN) begin
      r = SUM_MIN[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  logic [31:0]        last_left;
  logic [31:0]        last_right;
  logic [31:0]        dl;
  logic [31:0]        dr;
  logic [63:0]        prod;
  logic [55:0]        left16;
  logic [55:0]        right16;
  logic [55:0]        travel;
  logic [55:0]        dist_mag;
  logic               dist_neg;
  logic [56:0]        diff_mag;
  logic               diff_neg;
  logic [63:0]        tacc;
  logic [29:0]        turn_mag;
  logic [30:0]        dtheta;
  logic [31:0]        mid;
  logic               flip;
  logic signed [33:0] z;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic [31:0]        cmag;
  logic [31:0]        smag;
  logic               cneg;
  logic               sneg;
  logic [31:0]        hsum;
  logic [63:0]        pacc;
  logic [56:0]        stepmag;
  logic [57:0]        step;
  logic [58:0]        total;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_en;
  logic [31:0]        dl_mag;
  logic [31:0]        dr_mag;
  logic [63:0]        sprod_l;
  logic [63:0]        sprod_r;
  logic [56:0]        sum57;
  logic [56:0]        r_m_l;
  logic [56:0]        l_m_r;
  logic [88:0]        tsum;
  logic [87:0]        psum;
  logic [31:0]        fold_ang;
  logic               fold_flip;
  logic signed [33:0] sh_x;
  logic signed [33:0] sh_y;
  logic signed [33:0] atan_z;
  logic signed [33:0] neg_cx;
  logic signed [33:0] neg_cy;
  logic [31:0]        hwrap;

  // Magnitudes and signed products of the wheel deltas.
  assign dl_mag  = dl[31] ? (~dl + 32'd1) : dl;
  assign dr_mag  = dr[31] ? (~dr + 32'd1) : dr;
  assign sprod_l = dl[31] ? (~prod + 64'd1) : prod;
  assign sprod_r = dr[31] ? (~prod + 64'd1) : prod;

  // Distance and wheel difference.
  assign sum57 = {left16[55], left16} + {right16[55], right16};
  assign r_m_l = {right16[55], right16} - {left16[55], left16};
  assign l_m_r = {left16[55], left16} - {right16[55], right16};

  // Recombine the two partial products of the wide multiplications.
  assign tsum = {prod[56:0], 32'b0} + {25'b0, tacc};
  assign psum = {prod[55:0], 32'b0} + {24'b0, pacc};

  // Fold the midpoint angle into the CORDIC range.
  always_comb begin
    if ($signed(mid) > HALF_PI_Q28) begin
      fold_ang  = mid - PI_Q28;
      fold_flip = 1'b1;
    end else if ($signed(mid) < -HALF_PI_Q28) begin
      fold_ang  = mid + PI_Q28;
      fold_flip = 1'b1;
    end else begin
      fold_ang  = mid;
      fold_flip = 1'b0;
    end
  end

  // One CORDIC micro-rotation.
  assign sh_x   = cx >>> ctl.iter;
  assign sh_y   = cy >>> ctl.iter;
  assign atan_z = $signed({4'b0, ATAN_Q30[ctl.iter]});
  assign neg_cx = -cx;
  assign neg_cy = -cy;

  // Heading wrap into plus or minus pi.
  always_comb begin
    if ($signed(hsum) > PI_Q28) begin
      hwrap = hsum - TWO_PI_Q28;
    end else if ($signed(hsum) < -PI_Q28) begin
      hwrap = hsum + TWO_PI_Q28;
    end else begin
      hwrap = hsum;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (ctl.op)
      OP_MUL_L: begin
        mul_a  = dl_mag;
        mul_b  = count_scale;
        mul_en = 1'b1;
      end
      OP_MUL_R: begin
        mul_a  = dr_mag;
        mul_b  = count_scale;
        mul_en = 1'b1;
      end
      OP_MUL_TL: begin
        mul_a  = diff_mag[31:0];
        mul_b  = inv_wheelbase;
        mul_en = 1'b1;
      end
      OP_MUL_TH: begin
        mul_a  = {7'b0, diff_mag[56:32]};
        mul_b  = inv_wheelbase;
        mul_en = 1'b1;
      end
      OP_MUL_XL: begin
        mul_a  = dist_mag[31:0];
        mul_b  = cmag;
        mul_en = 1'b1;
      end
      OP_MUL_XH: begin
        mul_a  = {8'b0, dist_mag[55:32]};
        mul_b  = cmag;
        mul_en = 1'b1;
      end
      OP_MUL_YL: begin
        mul_a  = dist_mag[31:0];
        mul_b  = smag;
        mul_en = 1'b1;
      end
      OP_MUL_YH: begin
        mul_a  = {8'b0, dist_mag[55:32]};
        mul_b  = smag;
        mul_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Product register after the multiplier.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= {32'b0, mul_a} * {32'b0, mul_b};
    end
  end

  // Architectural state: previous counts and the pose.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
    end else begin
      unique case (ctl.op)
        OP_IDLE: begin
          if (take) begin
            last_left  <= count_left;
            last_right <= count_right;
          end
        end
        OP_MUL_XL: heading <= hwrap[30:0];
        OP_STEP_Y: pos_x   <= sat48(total);
        OP_SAT_Y:  pos_y   <= sat48(total);
        default: begin
        end
      endcase
    end
  end

  // Scratch registers between the steps of one update.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_IDLE: begin
        if (take) begin
          dl <= count_left - last_left;
          dr <= count_right - last_right;
        end
      end
      OP_MUL_R:  left16  <= sprod_l[63:8];
      OP_RSCALE: right16 <= sprod_r[63:8];
      OP_SUMS: begin
        travel   <= sum57[56:1];
        diff_neg <= $signed(right16) < $signed(left16);
        diff_mag <= ($signed(right16) < $signed(left16)) ? l_m_r : r_m_l;
      end
      OP_MUL_TL: begin
        dist_mag <= travel[55] ? (~travel + 56'd1) : travel;
        dist_neg <= travel[55];
      end
      OP_MUL_TH: tacc <= prod;
      OP_TURN: begin
        if ((|tsum[88:50]) || (tsum[49:20] > PI_MAG)) begin
          turn_mag <= PI_MAG;
        end else begin
          turn_mag <= tsum[49:20];
        end
      end
      OP_DTH: begin
        dtheta <= diff_neg ? (~{1'b0, turn_mag} + 31'd1) : {1'b0, turn_mag};
      end
      OP_MID: begin
        mid <= {heading[30], heading} + {{2{dtheta[30]}}, dtheta[30:1]};
      end
      OP_FOLD: begin
        z    <= $signed({fold_ang, 2'b00});
        flip <= fold_flip;
        cx   <= CORDIC_GAIN;
        cy   <= '0;
      end
      OP_ROT: begin
        if (!z[33]) begin
          cx <= cx - sh_y;
          cy <= cy + sh_x;
          z  <= z - atan_z;
        end else begin
          cx <= cx + sh_y;
          cy <= cy - sh_x;
          z  <= z + atan_z;
        end
      end
      OP_CS: begin
        cmag <= cx[33] ? neg_cx[31:0] : cx[31:0];
        smag <= cy[33] ? neg_cy[31:0] : cy[31:0];
        cneg <= flip ^ cx[33];
        sneg <= flip ^ cy[33];
        hsum <= {heading[30], heading} + {dtheta[30], dtheta};
      end
      OP_MUL_XH: pacc <= prod;
      OP_MUL_YL: stepmag <= psum[86:30];
      OP_MUL_YH: begin
        pacc <= prod;
        step <= (dist_neg ^ cneg) ? (~{1'b0, stepmag} + 58'd1) : {1'b0, stepmag};
      end
      OP_ACC_X: begin
        stepmag <= psum[86:30];
        total   <= {{11{pos_x[47]}}, pos_x} + {step[57], step};
      end
      OP_STEP_Y: begin
        step <= (dist_neg ^ sneg) ? (~{1'b0, stepmag} + 58'd1) : {1'b0, stepmag};
      end
      OP_ACC_Y: total <= {{11{pos_y[47]}}, pos_y} + {step[57], step};
      default: begin
      end
    endcase
  end

endmodule

### src/differential_odometry_update.sv
// Top level of the differential-drive odometry update: handshakes,
// configuration registers and the result register.
// Depends on dou_pkg, dou_seq and dou_dp.
//
//   Channel  Signals                                   Direction  Width
//   input    in_valid, in_ready, count_left/right      in         32 + 32
//   output   out_valid, out_ready, pose_x/y/theta      out        48 + 48 + 31
//   config   cfg_write, cfg_index, cfg_data            in         1 + 32
//
// An update starts only from the idle step, so a new pair of counts is taken
// only after the previous update has finished. The CORDIC loop runs on the
// shift-add unit and the other products on the shared 32x32 multiplier.
// The result register is loaded in the final step of the update.
// A result waiting in the output register stalls only the final step of the
// next update. Reset clears the pose and the stored counts and loads the
// configuration defaults.
module differential_odometry_update
  import dou_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        count_left,
  input  logic [31:0]        count_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pose_x,
  output logic signed [47:0] pose_y,
  output logic signed [30:0] pose_theta,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int ROT_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic [31:0]        count_scale;
  logic [31:0]        inv_wheelbase;
  ctl_t               ctl;
  stat_t              stat;
  logic               take;
  logic               publish;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [30:0] heading;

  // Handshake control.
  assign in_ready      = (ctl.op == OP_IDLE);
  assign take          = in_valid && in_ready;
  assign stat.in_valid = in_valid;
  assign stat.out_busy = out_valid && !out_ready;
  assign publish       = (ctl.op == OP_PUB) && !stat.out_busy;

  dou_seq #(
    .LOOP_STEPS(ROT_STEPS)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctl (ctl)
  );

  dou_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .take         (take),
    .count_left   (count_left),
    .count_right  (count_right),
    .count_scale  (count_scale),
    .inv_wheelbase(inv_wheelbase),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_scale   <= COUNT_SCALE_RST;
      inv_wheelbase <= INV_WHEELBASE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNT_SCALE:   count_scale   <= cfg_data;
        REG_INV_WHEELBASE: inv_wheelbase <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output valid flag; the result stays until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (publish) begin
      pose_x     <= pos_x;
      pose_y     <= pos_y;
      pose_theta <= heading;
    end
  end

endmodule

### tb/tb_differential_odometry_update.sv
`timescale 1ns / 100ps
// Self-checking testbench for differential_odometry_update: encoder counts go in,
// a fixed-point pose predictor in a small scoreboard class checks every pose out.
// Depends on dou_pkg and the RTL of differential_odometry_update.
module tb_differential_odometry_update;
  import dou_pkg::*;

  localparam int ROT_STEPS = 24;
  localparam int PHASE_ITEMS = 222;
  localparam int NUM_PHASES = 6;
  localparam longint PI_FIX = 64'sd843314857;
  localparam longint HALF_PI_FIX = 64'sd421657428;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint POSE_MAX = 64'sd140737488355327;
  localparam longint POSE_MIN = -POSE_MAX - 64'sd1;

  // Arctangent of 2^-i in Q2.30 for the rotation steps.
  localparam logic [31:0] ARCTAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [30:0] theta;
  } pose_t;

  // Pose predictor and the queue of poses still owed by the block.
  class OdometryScoreboard;
    logic [31:0] count_scale;
    logic [31:0] inv_wheelbase;
    logic [31:0] last_left;
    logic [31:0] last_right;
    longint pos_x;
    longint pos_y;
    longint heading;
    pose_t expected_poses[$];
    int failures;
    int mismatches;

    function new();
      count_scale = COUNT_SCALE_RST;
      inv_wheelbase = INV_WHEELBASE_RST;
      last_left = '0;
      last_right = '0;
      pos_x = 0;
      pos_y = 0;
      heading = 0;
      failures = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_COUNT_SCALE) count_scale = val;
      else inv_wheelbase = val;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    // Product shifted right with the magnitude truncated, capped at 2^62.
    function longint scaled_product(longint a, longint b, int sh);
      logic neg;
      logic [63:0] ua, ub;
      logic [127:0] prod;
      longint mag;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      ub = ub & 64'h0000_0000_FFFF_FFFF;
      prod = ({64'b0, ua} * {64'b0, ub}) >> sh;
      if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
      mag = prod[63:0];
      return neg ? -mag : mag;
    endfunction

    function longint clamp_pose(longint v);
      if (v > POSE_MAX) return POSE_MAX;
      if (v < POSE_MIN) return POSE_MIN;
      return v;
    endfunction

    // Rotation-mode CORDIC; angles past a right angle are folded by pi first.
    function void sin_cos(input longint angle, output longint cos_q30,
                          output longint sin_q30);
      logic flip;
      longint x, y, z, nx;
      flip = 1'b0;
      if (angle > HALF_PI_FIX) begin
        angle = angle - PI_FIX;
        flip = 1'b1;
      end else if (angle < -HALF_PI_FIX) begin
        angle = angle + PI_FIX;
        flip = 1'b1;
      end
      z = angle * 4;
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < ((ROT_STEPS > 32) ? 32 : ROT_STEPS); i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(ARCTAN_Q30[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(ARCTAN_Q30[i]);
        end
        x = nx;
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
    endfunction

    // Advance the predicted pose by one pair of encoder readings.
    function void note_counts(logic [31:0] cl, logic [31:0] cr);
      logic [31:0] dl32, dr32;
      longint dl, dr, scale, recip, left_mm, right_mm, travel, turn, mid, c, s;
      pose_t want;
      dl32 = cl - last_left;
      dr32 = cr - last_right;
      dl = {{32{dl32[31]}}, dl32};
      dr = {{32{dr32[31]}}, dr32};
      last_left = cl;
      last_right = cr;
      scale = {32'b0, count_scale};
      recip = {32'b0, inv_wheelbase};

      // Wheel travel in Q.16 and the turn in Q.28, limited to half a revolution.
      left_mm = (dl * scale) >>> 8;
      right_mm = (dr * scale) >>> 8;
      travel = (left_mm + right_mm) >>> 1;
      turn = scaled_product(right_mm - left_mm, recip, 20);
      if (turn > PI_FIX) turn = PI_FIX;
      else if (turn < -PI_FIX) turn = -PI_FIX;

      // Move along the heading taken halfway through the turn.
      mid = heading + (turn >>> 1);
      sin_cos(mid, c, s);
      pos_x = clamp_pose(pos_x + scaled_product(travel, c, 30));
      pos_y = clamp_pose(pos_y + scaled_product(travel, s, 30));

      heading = heading + turn;
      if (heading > PI_FIX) heading = heading - 2 * PI_FIX;
      else if (heading < -PI_FIX) heading = heading + 2 * PI_FIX;

      want.x = 48'(pos_x);
      want.y = 48'(pos_y);
      want.theta = 31'(heading);
      expected_poses.push_back(want);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (expected_poses.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pose x=%0d y=%0d theta=%0d", $realtime,
                   got.x, got.y, got.theta);
        return;
      end
      want = expected_poses.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.theta !== want.theta) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pose mismatch expected x=%0d y=%0d theta=%0d, got x=%0d y=%0d theta=%0d",
                   $realtime, want.x, want.y, want.theta, got.x, got.y, got.theta);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] count_left = '0;
  logic [31:0] count_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] pose_x;
  logic signed [47:0] pose_y;
  logic signed [30:0] pose_theta;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_COUNT_SCALE;
  logic [31:0] cfg_data = '0;

  OdometryScoreboard pose_board;
  logic steady = 1'b0;
  logic [31:0] sent_left = '0;
  logic [31:0] sent_right = '0;

  always #4 clk = ~clk;

  differential_odometry_update #(
    .CORDIC_STEPS(ROT_STEPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .count_left(count_left),
    .count_right(count_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pose_x(pose_x),
    .pose_y(pose_y),
    .pose_theta(pose_theta),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Check every pose transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pose_board.check_pose({pose_x, pose_y, pose_theta});
  end

  // Result side: sometimes ready early, sometimes a stall while a pose waits.
  initial begin : pose_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Present one pair of counts after a random gap and hold it until the transfer.
  task automatic send_counts(input logic [31:0] cl, input logic [31:0] cr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    count_left <= cl;
    count_right <= cr;
    do @(posedge clk); while (!in_ready);
    pose_board.note_counts(cl, cr);
    sent_left = cl;
    sent_right = cr;
    // Drop valid after the transfer so a held pair is not taken twice.
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    pose_board.set_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (pose_board.pending() != 0) @(negedge clk);
  endtask

  // Hand-picked moves at the reset configuration.
  task automatic run_directed();
    send_counts(32'd0, 32'd0);
    send_counts(32'd100, 32'd100);
    // A left turn of about three radians takes the heading close to pi.
    send_counts(32'd100, 32'd400);
    // Opposite wheel travel large enough to saturate the step turn.
    send_counts(-32'sd300, 32'd500);
    send_counts(-32'sd300, 32'd500);
    send_counts(-32'sd500, 32'd300);
    send_counts(-32'sd350, 32'd300);
    // Turns in steps of 1.5 rad push the midpoint across a right angle.
    repeat (3) send_counts(sent_left, sent_right + 32'd150);
    repeat (3) send_counts(sent_left + 32'd150, sent_right);
    // Largest deltas; repeated half-range moves drive the position to its rail.
    send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Deltas across the counter wrap.
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_counts(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  initial begin : stimulus
    int kind;
    int step;
    logic [31:0] nl, nr, scale_val, inv_val;
    pose_board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    // Each phase drains the block, loads a new configuration, then runs random moves.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin scale_val = COUNT_SCALE_RST; inv_val = INV_WHEELBASE_RST; end
        1: begin scale_val = 32'hFFFF_FFFF; inv_val = 32'hFFFF_FFFF; end
        2: begin scale_val = 32'h0000_0000; inv_val = 32'h0000_0001; end
        3: begin scale_val = $urandom; inv_val = $urandom_range(32'hFFFF_FFFF, 1); end
        // A zero reciprocal wheel spacing gives straight-line motion only.
        4: begin
          scale_val = $urandom_range(32'h0200_0000, 32'h0001_0000);
          inv_val = '0;
        end
        default: begin
          scale_val = $urandom_range(32'h0400_0000, 32'h0010_0000);
          inv_val = $urandom_range(32'h1000_0000, 32'h0010_0000);
        end
      endcase
      wait_drained();
      write_reg(REG_COUNT_SCALE, scale_val);
      write_reg(REG_INV_WHEELBASE, inv_val);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 100 == 0) steady = ($urandom_range(0, 2) == 0);
        // Now and then hold off until the block has returned every pose.
        if ($urandom_range(0, 63) == 0) wait_drained();
        kind = $urandom_range(0, 9);
        case (kind)
          0: begin
            nl = $urandom;
            nr = $urandom;
          end
          1: begin
            step = int'($urandom_range(0, 2000000)) - 1000000;
            nl = sent_left + step;
            nr = sent_right + step;
          end
          8: begin
            nl = sent_left + (int'($urandom_range(0, 2097152)) - 1048576);
            nr = sent_right + (int'($urandom_range(0, 2097152)) - 1048576);
          end
          9: begin
            nl = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            nr = $urandom_range(0, 1) ? 32'h8000_0000 : sent_right;
          end
          default: begin
            nl = sent_left + (int'($urandom_range(0, 4000)) - 2000);
            nr = sent_right + (int'($urandom_range(0, 4000)) - 2000);
          end
        endcase
        send_counts(nl, nr);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (64) @(posedge clk);
    if (pose_board.failures == 0 && pose_board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
